FILE: rtl/core/crde_pkg.sv
// Shared types, command codes and widths of the clipped raster draw engine.
// No dependencies; the front end, queue, back end and top level refer to this package.
`timescale 1ns / 1ps
`default_nettype none

package crde_pkg;

	localparam int SCREEN_WIDTH_DEF  = 80;
	localparam int SCREEN_HEIGHT_DEF = 48;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// internal coordinate width: holds centre +/- radius and start + length
	localparam int CW   = 13;
	localparam int DW   = 14;
	localparam int OPW  = 4;
	localparam int INW  = 11;
	localparam int RADW = 10;
	localparam int COLW = 16;

	localparam logic [OPW-1:0] OP_CLEAR = 4'd0;
	localparam logic [OPW-1:0] OP_PIXEL = 4'd1;
	localparam logic [OPW-1:0] OP_FILL  = 4'd2;
	localparam logic [OPW-1:0] OP_OUTL  = 4'd3;
	localparam logic [OPW-1:0] OP_HLINE = 4'd4;
	localparam logic [OPW-1:0] OP_VLINE = 4'd5;
	localparam logic [OPW-1:0] OP_CIRC  = 4'd6;
	localparam logic [OPW-1:0] OP_FCIRC = 4'd7;
	localparam logic [OPW-1:0] OP_READ  = 4'd8;

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [3:0] {
		K_NOP   = 4'd0,
		K_CLEAR = 4'd1,
		K_PIXEL = 4'd2,
		K_FILL  = 4'd3,
		K_OUTL  = 4'd4,
		K_HLINE = 4'd5,
		K_VLINE = 4'd6,
		K_CIRC  = 4'd7,
		K_FCIRC = 4'd8,
		K_READ  = 4'd9
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		coord_t            x;
		coord_t            y;
		coord_t            w;
		coord_t            h;
		logic [RADW-1:0]   r;
		logic [COLW-1:0]   color;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/crde_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                                           clk,
	input  wire                                           wr_en,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
	input  wire [WIDTH-1:0]                               wr_data,
	input  wire                                           rd_en,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/crde_front.sv
// Command front end: takes a word from the input ports and sorts it into a kind.
// Depends on crde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crde_front (
	input  wire                         take,
	input  wire [crde_pkg::OPW-1:0]     operation,
	input  wire signed [crde_pkg::INW-1:0] x_pos,
	input  wire signed [crde_pkg::INW-1:0] y_pos,
	input  wire signed [crde_pkg::INW-1:0] width,
	input  wire signed [crde_pkg::INW-1:0] height,
	input  wire [crde_pkg::RADW-1:0]    radius,
	input  wire [crde_pkg::COLW-1:0]    color,
	output logic                        push,
	output crde_pkg::cmd_t              cmd
);
	logic w_pos, h_pos;

	assign w_pos = (width > 0);
	assign h_pos = (height > 0);
	assign push  = take;

	always_comb begin
		cmd.x     = crde_pkg::CW'(x_pos);
		cmd.y     = crde_pkg::CW'(y_pos);
		cmd.w     = crde_pkg::CW'(width);
		cmd.h     = crde_pkg::CW'(height);
		cmd.r     = radius;
		cmd.color = color;
		priority case (operation)
			crde_pkg::OP_CLEAR: cmd.kind = crde_pkg::K_CLEAR;
			crde_pkg::OP_PIXEL: cmd.kind = crde_pkg::K_PIXEL;
			crde_pkg::OP_FILL:
				cmd.kind = (w_pos && h_pos) ? crde_pkg::K_FILL : crde_pkg::K_NOP;
			crde_pkg::OP_OUTL:
				cmd.kind = (w_pos && h_pos) ? crde_pkg::K_OUTL : crde_pkg::K_NOP;
			crde_pkg::OP_HLINE:
				cmd.kind = w_pos ? crde_pkg::K_HLINE : crde_pkg::K_NOP;
			crde_pkg::OP_VLINE:
				cmd.kind = h_pos ? crde_pkg::K_VLINE : crde_pkg::K_NOP;
			crde_pkg::OP_CIRC:  cmd.kind = crde_pkg::K_CIRC;
			crde_pkg::OP_FCIRC: cmd.kind = crde_pkg::K_FCIRC;
			crde_pkg::OP_READ:  cmd.kind = crde_pkg::K_READ;
			default:            cmd.kind = crde_pkg::K_NOP;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/crde_cmd_queue.sv
// Short command queue between the front end and the drawing back end.
// Depends on crde_pkg for the command word type.
`timescale 1ns / 1ps
`default_nettype none

module crde_cmd_queue #(
	parameter int DEPTH = crde_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire crde_pkg::cmd_t   cmd_in,
	output logic                  full,
	input  wire                   pop,
	output logic                  empty,
	output crde_pkg::cmd_t        cmd_out
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	crde_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full    = (count_q == NW'(DEPTH));
	assign empty   = (count_q == '0);
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/crde_back.sv
// Drawing back end: breaks each command into clipped spans and writes each span
// one pixel a cycle into the frame store. Depends on crde_pkg and crde_ram.
`timescale 1ns / 1ps
`default_nettype none

module crde_back #(
	parameter int SCREEN_WIDTH  = crde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = crde_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          empty,
	input  wire crde_pkg::cmd_t          cmd,
	output logic                         pop,
	output logic                         done,
	output logic [crde_pkg::COLW-1:0]    read_color
);
	localparam int CW = crde_pkg::CW;
	localparam int DW = crde_pkg::DW;
	localparam int N  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam logic signed [CW-1:0] LIM_W = CW'(SCREEN_WIDTH);
	localparam logic signed [CW-1:0] LIM_H = CW'(SCREEN_HEIGHT);
	localparam logic signed [CW-1:0] CZERO = '0;
	localparam logic signed [CW-1:0] CONE  = CW'(1);
	localparam logic signed [DW-1:0] DZERO = '0;
	localparam logic [AW-1:0] LAST_ADDR = AW'(N - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_CLEAR  = 10'b0000000010,
		S_RECT   = 10'b0000000100,
		S_OUTL   = 10'b0000001000,
		S_CIRC   = 10'b0000010000,
		S_SETUP  = 10'b0000100000,
		S_RUN    = 10'b0001000000,
		S_READ   = 10'b0010000000,
		S_RDATA  = 10'b0100000000,
		S_FINISH = 10'b1000000000
	} state_t;

	state_t                 state_q, ret_q;
	crde_pkg::kind_t        kind_q;
	crde_pkg::coord_t       cx_q, cy_q, w_q, h_q, row_q, row_end_q;
	crde_pkg::coord_t       px_q, py_q;
	logic signed [DW-1:0]   d_q;
	logic [2:0]             k_q;
	logic [crde_pkg::COLW-1:0] color_q, res_q;
	crde_pkg::coord_t       sx_q, sy_q, slen_q, cur_q, last_q;
	logic                   shor_q;
	logic [AW-1:0]          addr_q;

	// span clipping
	crde_pkg::coord_t fix, lo, hi, lim, flim, ca, cb, rowv, colv;
	logic             span_ok;
	logic [AW-1:0]    span_addr;

	// circle and outline job selection
	crde_pkg::coord_t ga, gb, jx, jy, jlen, py_n, px_n, dif;
	logic             jhor, circ_last;
	logic signed [DW-1:0] d_n;

	logic              ram_we, ram_re;
	logic [crde_pkg::COLW-1:0] ram_rd;
	logic              on_scr;

	always_comb begin
		fix  = shor_q ? sy_q : sx_q;
		lo   = shor_q ? sx_q : sy_q;
		hi   = lo + slen_q;
		lim  = shor_q ? LIM_W : LIM_H;
		flim = shor_q ? LIM_H : LIM_W;
		ca   = (lo < CZERO) ? CZERO : ((lo > lim) ? lim : lo);
		cb   = (hi < CZERO) ? CZERO : ((hi > lim) ? lim : hi);
		span_ok = (fix >= CZERO) && (fix < flim) && (slen_q > CZERO) && (ca < cb);
		rowv = shor_q ? fix : ca;
		colv = shor_q ? ca : fix;
		span_addr = AW'($unsigned(rowv)) * ROW_STEP + AW'($unsigned(colv));
	end

	always_comb begin
		jhor = 1'b1;
		ga   = px_q;
		gb   = py_q;
		jx   = cx_q;
		jy   = cy_q;
		jlen = CONE;
		circ_last = 1'b0;
		unique case (kind_q)
			crde_pkg::K_OUTL: begin
				jhor = !k_q[1];
				jx   = (k_q == 3'd3) ? cx_q + w_q - CONE : cx_q;
				jy   = (k_q == 3'd1) ? cy_q + h_q - CONE : cy_q;
				jlen = k_q[1] ? h_q : w_q;
			end
			crde_pkg::K_FCIRC: begin
				ga   = k_q[1] ? py_q : px_q;
				gb   = k_q[1] ? px_q : py_q;
				jx   = cx_q - ga;
				jy   = k_q[0] ? cy_q - gb : cy_q + gb;
				jlen = $signed({ga[CW-2:0], 1'b1});
				circ_last = (k_q == 3'd3);
			end
			default: begin
				ga   = k_q[2] ? py_q : px_q;
				gb   = k_q[2] ? px_q : py_q;
				jx   = k_q[0] ? cx_q - ga : cx_q + ga;
				jy   = k_q[1] ? cy_q - gb : cy_q + gb;
				circ_last = (k_q == 3'd7);
			end
		endcase
	end

	// midpoint step
	always_comb begin
		py_n = py_q + CONE;
		dif  = py_n - (px_q - CONE);
		if (d_q <= DZERO) begin
			px_n = px_q;
			d_n  = d_q + DW'($signed({py_n[CW-2:0], 1'b1}));
		end else begin
			px_n = px_q - CONE;
			d_n  = d_q + DW'($signed({dif[CW-2:0], 1'b1}));
		end
	end

	assign on_scr = (cmd.x >= CZERO) && (cmd.x < LIM_W) && (cmd.y >= CZERO) && (cmd.y < LIM_H);
	assign pop    = (state_q == S_IDLE) && !empty;
	assign ram_we = (state_q == S_RUN) || (state_q == S_CLEAR);
	assign ram_re = pop && (cmd.kind == crde_pkg::K_READ);

	crde_ram #(
		.WIDTH (crde_pkg::COLW),
		.DEPTH (N)
	) u_frame (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (addr_q),
		.wr_data (color_q),
		.rd_en   (ram_re),
		.rd_addr (AW'($unsigned(cmd.y)) * ROW_STEP + AW'($unsigned(cmd.x))),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q  <= cmd.kind;
			cx_q    <= cmd.x;
			cy_q    <= cmd.y;
			w_q     <= cmd.w;
			h_q     <= cmd.h;
			color_q <= cmd.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			done       <= 1'b0;
			read_color <= '0;
			res_q      <= '0;
			k_q        <= '0;
			px_q       <= '0;
			py_q       <= '0;
			d_q        <= '0;
			row_q      <= '0;
			row_end_q  <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			slen_q     <= '0;
			shor_q     <= 1'b1;
			cur_q      <= '0;
			last_q     <= '0;
			addr_q     <= '0;
		end else begin
			done       <= 1'b0;
			read_color <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						res_q <= '0;
						k_q   <= '0;
						sx_q  <= cmd.x;
						sy_q  <= cmd.y;
						ret_q <= S_FINISH;
						unique case (cmd.kind)
							crde_pkg::K_CLEAR: begin
								addr_q  <= '0;
								state_q <= S_CLEAR;
							end
							crde_pkg::K_PIXEL: begin
								slen_q  <= CONE;
								shor_q  <= 1'b1;
								state_q <= S_SETUP;
							end
							crde_pkg::K_HLINE: begin
								slen_q  <= cmd.w;
								shor_q  <= 1'b1;
								state_q <= S_SETUP;
							end
							crde_pkg::K_VLINE: begin
								slen_q  <= cmd.h;
								shor_q  <= 1'b0;
								state_q <= S_SETUP;
							end
							crde_pkg::K_FILL: begin
								row_q     <= (cmd.y < CZERO) ? CZERO : cmd.y;
								row_end_q <= (cmd.y + cmd.h > LIM_H) ? LIM_H : cmd.y + cmd.h;
								state_q   <= S_RECT;
							end
							crde_pkg::K_OUTL: state_q <= S_OUTL;
							crde_pkg::K_CIRC, crde_pkg::K_FCIRC: begin
								px_q    <= CW'($signed({1'b0, cmd.r}));
								py_q    <= CZERO;
								d_q     <= DW'(1) - DW'($signed({1'b0, cmd.r}));
								state_q <= S_CIRC;
							end
							crde_pkg::K_READ:
								state_q <= on_scr ? S_RDATA : S_FINISH;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= S_FINISH;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_RECT: begin
					if (row_q < row_end_q) begin
						sx_q    <= cx_q;
						sy_q    <= row_q;
						slen_q  <= w_q;
						shor_q  <= 1'b1;
						row_q   <= row_q + CONE;
						ret_q   <= S_RECT;
						state_q <= S_SETUP;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_OUTL: begin
					sx_q    <= jx;
					sy_q    <= jy;
					slen_q  <= jlen;
					shor_q  <= jhor;
					k_q     <= k_q + 3'd1;
					ret_q   <= (k_q == 3'd3) ? S_FINISH : S_OUTL;
					state_q <= S_SETUP;
				end
				S_CIRC: begin
					if (k_q == 3'd0 && px_q < py_q) begin
						state_q <= S_FINISH;
					end else begin
						sx_q    <= jx;
						sy_q    <= jy;
						slen_q  <= jlen;
						shor_q  <= 1'b1;
						ret_q   <= S_CIRC;
						state_q <= S_SETUP;
						if (circ_last) begin
							k_q  <= '0;
							px_q <= px_n;
							py_q <= py_n;
							d_q  <= d_n;
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				S_SETUP: begin
					if (span_ok) begin
						cur_q   <= ca;
						last_q  <= cb - CONE;
						addr_q  <= span_addr;
						state_q <= S_RUN;
					end else begin
						state_q <= ret_q;
					end
				end
				S_RUN: begin
					if (cur_q == last_q) begin
						state_q <= ret_q;
					end else begin
						cur_q  <= cur_q + CONE;
						addr_q <= addr_q + (shor_q ? AW'(1) : ROW_STEP);
					end
				end
				S_READ: state_q <= S_RDATA;
				S_RDATA: begin
					res_q   <= ram_rd;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					done       <= 1'b1;
					read_color <= res_q;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/clipped_raster_draw_engine_core.sv
// Top level of the clipped raster draw engine: front end, command queue and
// drawing back end. Depends on crde_pkg, crde_front, crde_cmd_queue, crde_back.
//
// channel  | handshake              | payload
// command  | start in, busy out     | operation x_pos y_pos width height radius color
// result   | done out (one cycle)   | read_color
//
// Each command writes one pixel a cycle within each clipped span, after a setup step per span.
// Clear writes every address of the frame store in turn.
// The single write port of the frame store sets the pace.
// Busy rises when the two-entry command queue is full. Reset clears control
// state only; the frame store holds nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module clipped_raster_draw_engine_core #(
	parameter int SCREEN_WIDTH  = crde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = crde_pkg::SCREEN_HEIGHT_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire [crde_pkg::OPW-1:0]         operation,
	input  wire signed [crde_pkg::INW-1:0]  x_pos,
	input  wire signed [crde_pkg::INW-1:0]  y_pos,
	input  wire signed [crde_pkg::INW-1:0]  width,
	input  wire signed [crde_pkg::INW-1:0]  height,
	input  wire [crde_pkg::RADW-1:0]        radius,
	input  wire [crde_pkg::COLW-1:0]        color,
	output logic                            done,
	output logic [crde_pkg::COLW-1:0]       read_color
);
	crde_pkg::cmd_t in_cmd, head_cmd;
	logic           push, pop, full, empty;

	assign busy = full;

	crde_front u_front (
		.take      (start && !full),
		.operation (operation),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.width     (width),
		.height    (height),
		.radius    (radius),
		.color     (color),
		.push      (push),
		.cmd       (in_cmd)
	);

	crde_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (in_cmd),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.cmd_out (head_cmd)
	);

	crde_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.cmd        (head_cmd),
		.pop        (pop),
		.done       (done),
		.read_color (read_color)
	);

endmodule

`default_nettype wire

FILE: rtl/core/crde_checker.sv
// Port-level checks of the draw engine, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module crde_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [15:0] read_color
);

	// every command passes through the idle state and its finish state, so results never abut
	a_no_abut: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobes in consecutive cycles");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> (read_color == 16'd0)) else $error("result word without strobe");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy rose without a command word");

	// the reset is asynchronous, so the outputs are quiet while it is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> (!done && !busy)) else $error("activity during reset");

endmodule

bind clipped_raster_draw_engine_core crde_checker u_crde_checker (.*);

`default_nettype wire
